>>> rtl/colmap_pkg.sv
// Shared types and constants for the palette index to RGB lookup.
package colmap_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned CntW       = 9;
  localparam int unsigned ChW        = 16;
  localparam int unsigned NumW       = 24;
  localparam int unsigned RcpW       = 32;

  localparam logic [ChW-1:0]  ChFull  = 16'hFFFF;
  localparam logic [18:0]     Rcp10k  = 19'(32'hFFFF_FFFF / 32'd10000);
  localparam logic [13:0]     Div10k  = 14'd10000;
  localparam logic [12:0]     BoneG   = 13'd7812;
  localparam logic [12:0]     BoneB   = 13'd4975;

  // Color map codes
  typedef enum logic [1:0] {
    MAP_GRAY = 2'd0,
    MAP_HOT  = 2'd1,
    MAP_COOL = 2'd2,
    MAP_BONE = 2'd3
  } map_e;

  // Register indexes on the config port
  typedef enum logic [7:0] {
    REG_MAP_SELECT  = 8'd0,
    REG_COLOR_COUNT = 8'd1
  } reg_e;

  // Hot map segment
  typedef enum logic [1:0] {
    SEG_RED   = 2'd0,
    SEG_GREEN = 2'd1,
    SEG_BLUE  = 2'd2
  } seg_e;

  // Reciprocal setup sequencer
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_RUN
  } cal_state_e;

  // Request to the serial divider
  typedef struct packed {
    logic             start;
    logic [RcpW-1:0]  dividend;
    logic [CntW-1:0]  divisor;
  } div_req_t;

endpackage

>>> rtl/colmap_div.sv
// Bit-serial restoring divider, 32-bit dividend, 9-bit divisor.
module colmap_div import colmap_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [RcpW-1:0] quot_o
);

  logic            busy_q, busy_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [RcpW-1:0] dvd_q, dvd_d;
  logic [RcpW-1:0] quo_q, quo_d;
  logic [CntW-1:0] dvs_q, dvs_d;
  logic            done_q, done_d;
  logic [CntW:0]   rem_sh;
  logic [CntW:0]   rem_sub;
  logic            fits;

  // One quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, dvd_q[RcpW-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      dvd_d = {dvd_q[RcpW-2:0], 1'b0};
      quo_d = {quo_q[RcpW-2:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/colormap_index_to_rgb_top.sv
// Top level of the palette index to RGB lookup pipeline.
//
// Usage:
//   s_axis carries one palette index per beat; m_axis returns one beat per
//   index with red, green, blue (16 bits each) and the packed 24-bit color.
//   The cfg channel writes map_select (index 0) or color_count (index 1).
// An accepted index moves through the registered pipeline stages to its output beat.
// Throughput: one index per clock once running, while the output is not stalled.
// After reset and after every config write, a serial divider builds three
//   reciprocals of the count-derived divisors and the gray step 65535/(count-1);
//   s_axis_tready stays low until they are done.
// Each per-item division by a count-derived divisor or by 10000 is a multiply
//   by a reciprocal followed by a one-step remainder correction, spread over the pipeline stages.
// When m_axis_tready is low with a beat waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
// Reset selects the gray map with 256 entries.
module colormap_index_to_rgb_top import colmap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // palette_index
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // red, green, blue, packed_rgb
);

  // Config registers
  logic [1:0]      map_q;
  logic [CntW-1:0] cnt_q;
  logic            cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= MAP_GRAY;
      cnt_q <= CntW'(MaxEntries);
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_MAP_SELECT:  map_q <= cfg_data_i[1:0];
        REG_COLOR_COUNT: cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Count-derived divisors
  logic [CntW-1:0] m_eff;
  logic [IdxW-1:0] dm1;
  logic [9:0]      m3;
  logic [6:0]      n_seg;
  logic [CntW-1:0] m2n;

  always_comb begin
    m_eff = cnt_q;
    if (cnt_q < 9'd2) m_eff = 9'd2;
    if (cnt_q > CntW'(MaxEntries)) m_eff = CntW'(MaxEntries);
    dm1   = IdxW'(m_eff - 9'd1);
    m3    = {1'b0, m_eff} + {m_eff, 1'b0};
    n_seg = m3[9:3];
    m2n   = m_eff - {1'b0, n_seg, 1'b0};
  end

  // Reciprocal setup sequencer
  cal_state_e      st_q, st_d;
  logic [1:0]      step_q;
  div_req_t        div_req;
  logic            div_done;
  logic [RcpW-1:0] div_quot;
  logic [RcpW-1:0] rcp_dm1_q, rcp_n_q, rcp_m2n_q;
  logic [ChW-1:0]  step_s_q;
  logic            run;

  colmap_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_LOAD: st_d = ST_WAIT;
      ST_WAIT: if (div_done) st_d = (step_q == 2'd3) ? ST_RUN : ST_LOAD;
      ST_RUN:  st_d = ST_RUN;
      default: st_d = ST_LOAD;
    endcase
    if (cfg_wr) st_d = ST_LOAD;
  end

  // Sequencer outputs
  always_comb begin
    div_req.start    = (st_q == ST_LOAD);
    div_req.dividend = '1;
    div_req.divisor  = {1'b0, dm1};
    run              = (st_q == ST_RUN);
    unique case (step_q)
      2'd0: div_req.divisor = {1'b0, dm1};
      2'd1: div_req.divisor = {2'b0, n_seg};
      2'd2: div_req.divisor = m2n;
      2'd3: begin
        div_req.dividend = RcpW'(ChFull);
        div_req.divisor  = {1'b0, dm1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_LOAD;
      step_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (cfg_wr) step_q <= 2'd0;
      else if (st_q == ST_WAIT && div_done) step_q <= step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_WAIT && div_done) begin
      unique case (step_q)
        2'd0: rcp_dm1_q <= div_quot;
        2'd1: rcp_n_q   <= div_quot;
        2'd2: rcp_m2n_q <= div_quot;
        2'd3: step_s_q  <= div_quot[ChW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages move together
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  assign en              = !v7_q || m_axis_tready_i;
  assign s_axis_tready_o = en && run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q} <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i && run;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // Stage 1: clamp index
  logic [IdxW-1:0] i1_q;
  logic [1:0]      sel1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      i1_q   <= (s_axis_tdata_i > dm1) ? dm1 : s_axis_tdata_i;
      sel1_q <= map_q;
    end
  end

  // Stage 2: gray level, hot segment and quotient numerator
  logic [ChW-1:0]  lvl2_q;
  logic [1:0]      sel2_q, seg2_q;
  logic [NumW-1:0] x2_q;
  logic [CntW-1:0] d2_q;
  logic [RcpW-1:0] r2_q;
  logic [23:0]     is_prod;
  logic [8:0]      num;
  logic [CntW-1:0] dsel;
  logic [RcpW-1:0] rsel;
  logic [1:0]      seg;
  logic [24:0]     xnum;

  always_comb begin
    is_prod = i1_q * step_s_q;
    seg     = SEG_RED;
    num     = {1'b0, i1_q};
    dsel    = {1'b0, dm1};
    rsel    = rcp_dm1_q;
    if (sel1_q == MAP_HOT) begin
      if ({1'b0, i1_q} < {2'b0, n_seg}) begin
        num  = {1'b0, i1_q} + 9'd1;
        dsel = {2'b0, n_seg};
        rsel = rcp_n_q;
      end else if ({1'b0, i1_q} < {1'b0, n_seg, 1'b0}) begin
        seg  = SEG_GREEN;
        num  = {1'b0, i1_q} - {2'b0, n_seg} + 9'd1;
        dsel = {2'b0, n_seg};
        rsel = rcp_n_q;
      end else begin
        seg  = SEG_BLUE;
        num  = {1'b0, i1_q} - {1'b0, n_seg, 1'b0} + 9'd1;
        dsel = m2n;
        rsel = rcp_m2n_q;
      end
    end
    xnum = {num, 16'b0} - {16'b0, num};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lvl2_q <= ChFull - is_prod[ChW-1:0];
      sel2_q <= sel1_q;
      seg2_q <= seg;
      x2_q   <= xnum[NumW-1:0];
      d2_q   <= dsel;
      r2_q   <= rsel;
    end
  end

  // Stage 3: reciprocal products
  logic [55:0]     p3_q;
  logic [28:0]     bg3_q, bb3_q;
  logic [ChW-1:0]  lvl3_q;
  logic [1:0]      sel3_q, seg3_q;
  logic [NumW-1:0] x3_q;
  logic [CntW-1:0] d3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q   <= x2_q * r2_q;
      bg3_q  <= lvl2_q * BoneG;
      bb3_q  <= lvl2_q * BoneB;
      lvl3_q <= lvl2_q;
      sel3_q <= sel2_q;
      seg3_q <= seg2_q;
      x3_q   <= x2_q;
      d3_q   <= d2_q;
    end
  end

  // Stage 4: quotient estimate and remainder, bone reciprocal products
  logic [ChW-1:0]  q4_q;
  logic [CntW:0]   rem4_q;
  logic [47:0]     pg4_q, pb4_q;
  logic [28:0]     bg4_q, bb4_q;
  logic [ChW-1:0]  lvl4_q;
  logic [1:0]      sel4_q, seg4_q;
  logic [CntW-1:0] d4_q;
  logic [ChW-1:0]  q0;
  logic [24:0]     qd;
  logic [24:0]     rem_full;

  always_comb begin
    q0       = p3_q[47:32];
    qd       = q0 * d3_q;
    rem_full = {1'b0, x3_q} - qd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q4_q   <= q0;
      rem4_q <= rem_full[CntW:0];
      pg4_q  <= bg3_q * Rcp10k;
      pb4_q  <= bb3_q * Rcp10k;
      bg4_q  <= bg3_q;
      bb4_q  <= bb3_q;
      lvl4_q <= lvl3_q;
      sel4_q <= sel3_q;
      seg4_q <= seg3_q;
      d4_q   <= d3_q;
    end
  end

  // Stage 5: quotient correction and channel selection
  logic [ChW-1:0] r5_q, g5_q, b5_q;
  logic [ChW-1:0] q5, gq, bq, rb;
  logic [16:0]    q5w, gqw, bqw;
  logic [29:0]    gm, bm;
  logic [29:0]    grem, brem;
  logic [18:0]    lvl5x;
  logic [ChW-1:0] rc, gc, bc;

  always_comb begin
    q5w   = {1'b0, q4_q} + {16'b0, (rem4_q >= {1'b0, d4_q})};
    q5    = q5w[ChW-1:0];
    gm    = pg4_q[47:32] * Div10k;
    bm    = pb4_q[47:32] * Div10k;
    grem  = {1'b0, bg4_q} - gm;
    brem  = {1'b0, bb4_q} - bm;
    gqw   = {1'b0, pg4_q[47:32]} + {16'b0, (grem >= 30'(Div10k))};
    bqw   = {1'b0, pb4_q[47:32]} + {16'b0, (brem >= 30'(Div10k))};
    gq    = gqw[ChW-1:0];
    bq    = bqw[ChW-1:0];
    // 5*level/4, saturated once the quotient needs a 17th bit
    lvl5x = {3'b0, lvl4_q} + {1'b0, lvl4_q, 2'b0};
    rb    = lvl5x[18] ? ChFull : lvl5x[17:2];
    rc = lvl4_q;
    gc = lvl4_q;
    bc = lvl4_q;
    case (sel4_q)
      MAP_HOT: begin
        case (seg4_q)
          SEG_RED:   begin rc = q5;     gc = '0;     bc = '0; end
          SEG_GREEN: begin rc = ChFull; gc = q5;     bc = '0; end
          default:   begin rc = ChFull; gc = ChFull; bc = q5; end
        endcase
      end
      MAP_COOL: begin
        rc = q5;
        gc = ChFull - q5;
        bc = ChFull;
      end
      MAP_BONE: begin
        rc = rb;
        gc = gq;
        bc = bq;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r5_q <= rc;
      g5_q <= gc;
      b5_q <= bc;
    end
  end

  // Stage 6: palette scaling products
  logic [ChW-1:0] r6_q, g6_q, b6_q;
  logic [23:0]    pr6_q, pg6_q, pb6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r6_q  <= r5_q;
      g6_q  <= g5_q;
      b6_q  <= b5_q;
      pr6_q <= r5_q * dm1;
      pg6_q <= g5_q * dm1;
      pb6_q <= b5_q * dm1;
    end
  end

  // Stage 7: divide by 65535 and output register
  function automatic logic [7:0] div_full(input logic [23:0] p);
    logic [16:0] r;
    logic [8:0]  q;
    r = {1'b0, p[15:0]} + {9'b0, p[23:16]};
    q = {1'b0, p[23:16]} + {8'b0, (r >= {1'b0, ChFull})};
    return q[7:0];
  endfunction

  logic [71:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {div_full(pr6_q), div_full(pg6_q), div_full(pb6_q), b6_q, g6_q, r6_q};
    end
  end

  assign m_axis_tvalid_o = v7_q;
  assign m_axis_tdata_o  = out_q;

  // A config write restarts the reciprocal setup and blocks input
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !s_axis_tready_o)
    else $error("input open right after config write");

  // Packed red byte never exceeds count-1
  a_pack_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[71:64] <= dm1))
    else $error("packed red beyond palette range");

  // A held output beat freezes the stage feeding it
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && !m_axis_tready_i) |=> $stable(v6_q) && $stable(r6_q))
    else $error("pipeline moved during stall");

endmodule
